// ----- rtl/core/point_in_convex_polygon_core_assert.svh -----
// Assertion macros for the point-in-convex-polygon core.
// Needs signals named clock and reset in the including module.
`ifndef POINT_IN_CONVEX_POLYGON_CORE_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define PIP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be seen.
`define PIP_ASSERT_NEVER(label, cond, msg) \
   `PIP_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/core/pip_pkg.sv -----
// Shared types and constants of the point-in-convex-polygon core.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int COORD_W = 16;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   typedef logic signed [COORD_W-1:0]     coord_type;
   typedef logic signed [COORD_W:0]       diff_type;
   typedef logic signed [2*COORD_W+1:0]   prod_type;
   typedef logic signed [2*COORD_W+2:0]   cross_type;
   typedef logic [INDEX_W-1:0]            index_type;
   typedef logic [COUNT_W-1:0]            count_type;

   localparam logic      ACT_LOAD  = 1'b0;
   localparam logic      ACT_QUERY = 1'b1;

   localparam logic      REG_VERTEX_COUNT = 1'b0;
   localparam count_type VERTEX_COUNT_RESET = 7'd3;
   localparam int        MIN_VERTICES = 3;

endpackage

// ----- rtl/core/pip_if.sv -----
// Valid/ready channel interfaces: request words in, response words out.
// Depends on pip_pkg.
`timescale 1ns / 1ps

interface pip_req_if;
   import pip_pkg::*;

   logic      valid;
   logic      ready;
   logic      action;
   index_type vertex_index;
   coord_type coord_x;
   coord_type coord_y;

   modport source (output valid, output action, output vertex_index,
                   output coord_x, output coord_y, input ready);
   modport sink   (input valid, input action, input vertex_index,
                   input coord_x, input coord_y, output ready);
endinterface

interface pip_rsp_if;
   import pip_pkg::*;

   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

// ----- rtl/core/point_in_convex_polygon_core.sv -----
// Point-in-convex-polygon core (uses pip_pkg, pip_if, pip_ram): a load word goes straight
// into the vertex table; a query walks the edges on the one shared 17x17 multiplier (two
// products per edge) and gives its result at the end of the walk, earlier on early exit.
// One word at a time: after a query the next word waits until its result is handed on.
// Synchronous active-high reset clears control and vertex_count (to 3); the vertex table
// is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module point_in_convex_polygon_core #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   pip_req_if.sink     req_if,
   pip_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pip_pkg::*;
   `include "point_in_convex_polygon_core_assert.svh"

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;   // vertex 0 arrives from the table
   localparam logic [2:0] S_EDGE  = 3'd2;   // next vertex arrives, vertex hit check
   localparam logic [2:0] S_MUL1  = 3'd3;   // (px - x1) * (y2 - y1)
   localparam logic [2:0] S_MUL2  = 3'd4;   // (py - y1) * (x2 - x1)
   localparam logic [2:0] S_SIGN  = 3'd5;   // difference, sign flags, step on
   localparam logic [2:0] S_DONE  = 3'd6;   // hand result to response register

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   coord_type     px_ff, px_in, py_ff, py_in;
   coord_type     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type     first_x_ff, first_x_in, first_y_ff, first_y_in;
   coord_type     nxt_x_ff, nxt_x_in, nxt_y_ff, nxt_y_in;
   prod_type      mul_ff, mul_in;
   prod_type      p1_ff, p1_in;
   logic          pos_ff, pos_in, neg_ff, neg_in;
   logic          result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_inside_ff, rsp_inside_in;
   count_type     vc_ff, vc_in;

   // --------------------------------------------------------------------------
   // Register port: one register, vertex_count, at byte address 0.
   // --------------------------------------------------------------------------
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);
   assign vc_in  = csr_wr ? pwdata[COUNT_W-1:0] : vc_ff;

   always_comb begin
      if (paddr[2] == REG_VERTEX_COUNT) begin
         prdata = 32'(vc_ff);
      end else begin
         prdata = '0;
      end
   end

   // Count in use, clamped to [3, MAX_VERTICES].
   logic [31:0]   vc_wide, n_wide;
   logic [CW-1:0] n_used;

   always_comb begin
      vc_wide = 32'(vc_ff);
      if (vc_wide < 32'(MIN_VERTICES)) begin
         n_wide = 32'(MIN_VERTICES);
      end else if (vc_wide > 32'(MAX_VERTICES)) begin
         n_wide = 32'(MAX_VERTICES);
      end else begin
         n_wide = vc_wide;
      end
   end
   assign n_used = n_wide[CW-1:0];

   // --------------------------------------------------------------------------
   // Vertex table: x in the upper half of each word, y in the lower.
   // --------------------------------------------------------------------------
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [2*COORD_W-1:0] ram_rd_data;
   coord_type            rd_x, rd_y;
   logic                 req_take, slot_ok;

   assign req_take    = req_if.valid && req_if.ready;
   assign slot_ok     = 32'(req_if.vertex_index) < 32'(MAX_VERTICES);
   assign ram_wr_en   = req_take && (req_if.action == ACT_LOAD) && slot_ok;
   assign ram_wr_addr = AW'(req_if.vertex_index);
   assign rd_x        = ram_rd_data[2*COORD_W-1:COORD_W];
   assign rd_y        = ram_rd_data[COORD_W-1:0];

   pip_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_if.coord_x, req_if.coord_y}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // --------------------------------------------------------------------------
   // Shared multiplier: operand set chosen by the sequencer step.
   // --------------------------------------------------------------------------
   diff_type  mul_a, mul_b;
   cross_type cross_val;

   always_comb begin
      if (state_ff == S_MUL2) begin
         mul_a = diff_type'(py_ff) - diff_type'(cur_y_ff);
         mul_b = diff_type'(nxt_x_ff) - diff_type'(cur_x_ff);
      end else begin
         mul_a = diff_type'(px_ff) - diff_type'(cur_x_ff);
         mul_b = diff_type'(nxt_y_ff) - diff_type'(cur_y_ff);
      end
      mul_in = prod_type'(mul_a) * prod_type'(mul_b);
   end

   assign cross_val = cross_type'(p1_ff) - cross_type'(mul_ff);

   // edge bookkeeping
   logic [CW-1:0] idx_next;
   logic [CW:0]   idx_plus2;
   logic          last_edge, hit;

   assign idx_next  = CW'(idx_ff) + CW'(1);
   assign idx_plus2 = (CW + 1)'(idx_ff) + (CW + 1)'(2);
   assign last_edge = (idx_next == n_used);
   assign hit       = (cur_x_ff == px_ff) && (cur_y_ff == py_ff);

   assign req_if.ready = (state_ff == S_IDLE);

   // --------------------------------------------------------------------------
   // Sequencer
   // --------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      nxt_x_in      = nxt_x_ff;
      nxt_y_in      = nxt_y_ff;
      p1_in         = p1_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      result_in     = result_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_inside_in = rsp_inside_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && (req_if.action == ACT_QUERY)) begin
               px_in       = req_if.coord_x;
               py_in       = req_if.coord_y;
               pos_in      = 1'b0;
               neg_in      = 1'b0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = S_FIRST;
            end
         end
         S_FIRST: begin
            cur_x_in    = rd_x;
            cur_y_in    = rd_y;
            first_x_in  = rd_x;
            first_y_in  = rd_y;
            idx_in      = '0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(1);
            state_in    = S_EDGE;
         end
         S_EDGE: begin
            // closing edge runs back to vertex 0
            if (last_edge) begin
               nxt_x_in = first_x_ff;
               nxt_y_in = first_y_ff;
            end else begin
               nxt_x_in = rd_x;
               nxt_y_in = rd_y;
            end
            if (hit) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in  = S_MUL1;
            end
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            p1_in    = mul_ff;
            state_in = S_SIGN;
         end
         S_SIGN: begin
            if (cross_val > 0) begin
               pos_in = 1'b1;
            end
            if (cross_val < 0) begin
               neg_in = 1'b1;
            end
            if (pos_in && neg_in) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else if (last_edge) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_next[AW-1:0];
               cur_x_in = nxt_x_ff;
               cur_y_in = nxt_y_ff;
               // prefetch the vertex after next; not needed on the closing edge
               if (idx_plus2 < (CW + 1)'(n_used)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_plus2[AW-1:0];
               end
               state_in = S_EDGE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = result_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vc_ff        <= VERTEX_COUNT_RESET;
         pos_ff       <= 1'b0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vc_ff        <= vc_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      first_x_ff    <= first_x_in;
      first_y_ff    <= first_y_in;
      nxt_x_ff      <= nxt_x_in;
      nxt_y_ff      <= nxt_y_in;
      mul_ff        <= mul_in;
      p1_ff         <= p1_in;
      result_ff     <= result_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.inside_res = rsp_inside_ff;

   // --------------------------------------------------------------------------
   // Checks
   // --------------------------------------------------------------------------
   logic query_take, idx_in_range, both_signs;

   assign query_take   = req_take && (req_if.action == ACT_QUERY);
   assign idx_in_range = (idx_next <= n_used);
   assign both_signs   = pos_ff && neg_ff;

   `PIP_ASSERT(a_query_starts_walk, query_take |=> (state_ff == S_FIRST), "query did not start")
   `PIP_ASSERT(a_idx_in_range, (state_ff == S_EDGE) |-> idx_in_range, "edge index past count")
   `PIP_ASSERT_NEVER(a_walk_after_outside, (state_ff == S_EDGE) && both_signs, "walk kept going")
   `PIP_ASSERT(a_rsp_from_done, $rose(rsp_if.valid) |-> $past(state_ff == S_DONE), "stray word")

endmodule

// ----- rtl/core/pip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for point_in_convex_polygon_core: vertex loads and point queries
// go in as request words, answers are predicted in place, vertex_count is set over APB.
// Depends on pip_pkg, the channel interfaces in pip_if.sv and the core itself.
`timescale 1ns / 1ps

module testbench;
   import pip_pkg::*;

   localparam int MAX_V        = 64;
   localparam int WORD_TARGET  = 1800;
   localparam int DRAIN_CYCLES = 4*MAX_V + 16;   // one full-size query and then some
   localparam int IDLE_PCT     = 31;
   localparam int DIR_LEN      = 23;
   localparam logic [2:0] COUNT_ADDR = 3'(REG_VERTEX_COUNT) << 2;

   typedef struct packed {
      logic      action;
      index_type slot;
      coord_type x;
      coord_type y;
   } req_word_type;

   typedef struct packed {
      req_word_type word;
      bit           known;    // answer typed in below, else taken from the predictor
      bit           answer;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pip_req_if req_bus ();
   pip_rsp_if rsp_bus ();

   point_in_convex_polygon_core #(.MAX_VERTICES(MAX_V)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the vertex table and the count register
   coord_type shadow_x [MAX_V];
   coord_type shadow_y [MAX_V];
   count_type shadow_count = VERTEX_COUNT_RESET;
   bit        inside_due [$];

   int words_sent = 0;
   int mismatches = 0;
   bit steady     = 1'b0;   // no idling on either side while set

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   function automatic int used_vertices();
      int n;
      n = int'(shadow_count);
      if (n < MIN_VERTICES)
         n = MIN_VERTICES;
      if (n > MAX_V)
         n = MAX_V;
      return n;
   endfunction

   // Edge walk from vertex 0: vertex hit means inside, both cross signs mean outside.
   function automatic bit covers_point(input coord_type px, input coord_type py);
      int     n, i, j;
      bit     pos, neg;
      longint x1, y1, x2, y2, d;
      n   = used_vertices();
      pos = 1'b0;
      neg = 1'b0;
      for (i = 0; i < n; i++) begin
         j  = (i + 1 < n) ? i + 1 : 0;
         x1 = longint'(shadow_x[i]);
         y1 = longint'(shadow_y[i]);
         x2 = longint'(shadow_x[j]);
         y2 = longint'(shadow_y[j]);
         if (shadow_x[i] == px && shadow_y[i] == py)
            return 1'b1;
         d = (longint'(px) - x1) * (y2 - y1) - (longint'(py) - y1) * (x2 - x1);
         if (d > 0)
            pos = 1'b1;
         if (d < 0)
            neg = 1'b1;
         if (pos && neg)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic dir_row_type dir_entry(input logic act, input int slot, input int x,
                                             input int y, input bit known, input bit answer);
      dir_row_type r;
      r.word.action = act;
      r.word.slot   = index_type'(slot);
      r.word.x      = coord_type'(x);
      r.word.y      = coord_type'(y);
      r.known       = known;
      r.answer      = answer;
      return r;
   endfunction

   // count is 3 after reset: small triangle, spare slots, same triangle clockwise,
   // then a triangle spanning the whole coordinate range (widest cross products)
   dir_row_type dir_rows [DIR_LEN] = '{
      dir_entry(ACT_LOAD,   0,      0,      0, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   1,    256,      0, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   2,      0,    256, 1'b0, 1'b0),
      dir_entry(ACT_QUERY,  0,      0,      0, 1'b1, 1'b1),
      dir_entry(ACT_QUERY,  0,     64,     64, 1'b1, 1'b1),
      dir_entry(ACT_QUERY,  0,    128,      0, 1'b1, 1'b1),
      dir_entry(ACT_QUERY, 63,  32767,  32767, 1'b1, 1'b0),
      dir_entry(ACT_QUERY,  0, -32768, -32768, 1'b1, 1'b0),
      dir_entry(ACT_QUERY,  0,    256,    256, 1'b1, 1'b0),
      dir_entry(ACT_QUERY,  0,      0,    256, 1'b1, 1'b1),
      dir_entry(ACT_LOAD,  63,  32767, -32768, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,  62, -32768,  32767, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   1,      0,    256, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   2,    256,      0, 1'b0, 1'b0),
      dir_entry(ACT_QUERY, 21,     64,     64, 1'b1, 1'b1),
      dir_entry(ACT_LOAD,   0, -32768, -32768, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   1,  32767, -32768, 1'b0, 1'b0),
      dir_entry(ACT_LOAD,   2, -32768,  32767, 1'b0, 1'b0),
      dir_entry(ACT_QUERY,  0,     -1,     -1, 1'b1, 1'b1),
      dir_entry(ACT_QUERY, 63,      0,      0, 1'b1, 1'b0),
      dir_entry(ACT_QUERY,  0,  32767,  32767, 1'b1, 1'b0),
      dir_entry(ACT_QUERY,  0, -32768,  32767, 1'b1, 1'b1),
      dir_entry(ACT_QUERY, 42, -32768,      0, 1'b0, 1'b0)
   };

   // Called and returns at a falling edge; valid is left high for back-to-back words.
   task automatic put_word(input req_word_type w, input bit known, input bit answer);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.action       = w.action;
      req_bus.vertex_index = w.slot;
      req_bus.coord_x      = w.x;
      req_bus.coord_y      = w.y;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (w.action == ACT_LOAD) begin
         shadow_x[w.slot] = w.x;
         shadow_y[w.slot] = w.y;
      end else begin
         inside_due = {inside_due, (known ? answer : covers_point(w.x, w.y))};
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_load(input int slot, input int x, input int y);
      req_word_type w;
      w.action = ACT_LOAD;
      w.slot   = index_type'(slot);
      w.x      = coord_type'(x);
      w.y      = coord_type'(y);
      put_word(w, 1'b0, 1'b0);
   endtask

   task automatic send_query(input int x, input int y);
      req_word_type w;
      x = (x < -32768) ? -32768 : (x > 32767) ? 32767 : x;
      y = (y < -32768) ? -32768 : (y > 32767) ? 32767 : y;
      w.action = ACT_QUERY;
      w.slot   = index_type'($urandom_range(63));   // don't-care on a query
      w.x      = coord_type'(x);
      w.y      = coord_type'(y);
      put_word(w, 1'b0, 1'b0);
   endtask

   // Convex-ish polygon on a jittered circle; rounding can make tiny ones degenerate.
   task automatic load_polygon(input int n);
      int  scale_pick, r, cx, cy, k;
      bit  cw, rev;
      real ang0, ang;
      scale_pick = $urandom_range(9);
      if (scale_pick == 0)
         r = 0;
      else if (scale_pick < 4)
         r = $urandom_range(64, 1);
      else if (scale_pick < 8)
         r = $urandom_range(2048, 64);
      else
         r = $urandom_range(16000, 2048);
      cx   = int'($urandom_range(65533 - 2*r)) - 32767 + r;
      cy   = int'($urandom_range(65533 - 2*r)) - 32767 + r;
      cw   = $urandom_range(1);
      rev  = $urandom_range(1);
      ang0 = 6.283185307 * $urandom_range(999) / 1000.0;
      for (k = 0; k < n; k++) begin
         ang = ang0 + 6.283185307 * (k + 0.8 * $urandom_range(1000) / 1000.0) / n;
         if (cw)
            ang = -ang;
         send_load(rev ? n - 1 - k : k, cx + int'(r * $cos(ang)), cy + int'(r * $sin(ang)));
      end
   endtask

   // One random word against the loaded polygon: mostly queries, some stray loads.
   task automatic send_probe(input int n);
      int kind, i, j, lo_x, hi_x, lo_y, hi_y, mx, my;
      int corner_vals [4];
      corner_vals = '{-32768, -1, 0, 32767};
      kind = $urandom_range(99);
      i    = $urandom_range(n - 1);
      j    = (i + 1 < n) ? i + 1 : 0;
      if (kind < 40) begin
         // around the bounding box
         lo_x = shadow_x[0];
         hi_x = shadow_x[0];
         lo_y = shadow_y[0];
         hi_y = shadow_y[0];
         for (int k = 1; k < n; k++) begin
            if (shadow_x[k] < lo_x) lo_x = shadow_x[k];
            if (shadow_x[k] > hi_x) hi_x = shadow_x[k];
            if (shadow_y[k] < lo_y) lo_y = shadow_y[k];
            if (shadow_y[k] > hi_y) hi_y = shadow_y[k];
         end
         mx = (hi_x - lo_x) / 4 + 2;
         my = (hi_y - lo_y) / 4 + 2;
         send_query(lo_x - mx + int'($urandom_range(hi_x - lo_x + 2*mx)),
                    lo_y - my + int'($urandom_range(hi_y - lo_y + 2*my)));
      end else if (kind < 55) begin
         send_query(shadow_x[i], shadow_y[i]);
      end else if (kind < 72) begin
         // on or next to an edge
         mx = (int'(shadow_x[i]) + int'(shadow_x[j])) >>> 1;
         my = (int'(shadow_y[i]) + int'(shadow_y[j])) >>> 1;
         if ($urandom_range(1))
            send_query(mx, my);
         else
            send_query(mx + int'($urandom_range(2)) - 1, my + int'($urandom_range(2)) - 1);
      end else if (kind < 82) begin
         send_query(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
      end else if (kind < 90) begin
         send_query(corner_vals[$urandom_range(3)], corner_vals[$urandom_range(3)]);
      end else begin
         send_load($urandom_range(63), int'($urandom_range(65535)) - 32768,
                   int'($urandom_range(65535)) - 32768);
      end
   endtask

   task automatic csr_write(input count_type value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = COUNT_ADDR;
      pwdata  = $urandom;
      pwdata[COUNT_W-1:0] = value;
      @(negedge clock) penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      shadow_count = value;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_check(input count_type want);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = COUNT_ADDR;
      @(negedge clock) penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata[COUNT_W-1:0] !== want)
         report_mismatch($sformatf("vertex_count reads %0d, wrote %0d",
                                   prdata[COUNT_W-1:0], want));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // all answers in, then room for a trailing load or query to finish
   task automatic settle();
      req_bus.valid = 1'b0;
      while (inside_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_bus.ready = reset ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin : watch_answers
      bit want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (inside_due.size() == 0) begin
            report_mismatch("answer word with no query pending");
         end else begin
            want = inside_due.pop_front();
            if (rsp_bus.inside_res !== want)
               report_mismatch($sformatf("inside_res %b, predicted %b",
                                         rsp_bus.inside_res, want));
         end
      end
   end

   initial begin : stimulus
      count_type phase_counts [12];
      count_type setting;
      int        phase, n, budget, k;
      phase_counts = '{7'd0, 7'd1, 7'd2, 7'd4, 7'd64, 7'd5, 7'd127, 7'd8, 7'd65, 7'd3,
                       7'd6, 7'd32};
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_LOAD;
      req_bus.vertex_index = '0;
      req_bus.coord_x      = '0;
      req_bus.coord_y      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      csr_check(VERTEX_COUNT_RESET);
      for (k = 0; k < DIR_LEN; k++)
         put_word(dir_rows[k].word, dir_rows[k].known, dir_rows[k].answer);
      settle();

      // each phase: new count, fresh polygon over every used slot, then probes
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         if (phase < 12)
            setting = phase_counts[phase];
         else if ($urandom_range(9) == 0)
            setting = count_type'($urandom_range(127));
         else
            setting = count_type'($urandom_range(12, 3));
         steady = (phase >= 3 && phase <= 5);
         csr_write(setting);
         csr_check(setting);
         n = used_vertices();
         load_polygon(n);
         budget = (n > 16) ? 25 : 70;
         for (k = 0; k < budget; k++) begin
            if ($urandom_range(99) < 3)
               load_polygon(n);
            else
               send_probe(n);
         end
         settle();
         phase++;
      end
      steady = 1'b0;

      if (mismatches == 0 && inside_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
